[rtl/core/svb_pkg.sv]
package svb_pkg;

  localparam int SW = 16;

  localparam logic [31:0] PHASE_SEED = 32'h9e3779b9;
  localparam logic [63:0] SEMI_Q30   = 64'd1137589835;
  localparam logic [31:0] A4_INC     = 32'd39370534;
  localparam int          ENV_FULL   = 32767;

  localparam int CHORD [16] = '{26, 38, 50, 57, 62, 69, 74, 81,
                                62, 69, 74, 81, 86, 86, 90, 90};

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VMUL1,
    ST_VINC,
    ST_VMUL2,
    ST_VACC,
    ST_SMUL,
    ST_SADD,
    ST_DMOD,
    ST_DRD,
    ST_DWAIT,
    ST_DWR,
    ST_RRD,
    ST_RWAIT,
    ST_RWR,
    ST_RMIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic latch;
    logic vmul1;
    logic vinc;
    logic vmul2;
    logic vacc;
    logic smul;
    logic sadd;
    logic dmod_step;
    logic drd;
    logic dwr;
    logic rrd;
    logic rwr;
    logic rmix;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic dmod_done;
    logic vlast;
    logic out_free;
  } status_t;

  function automatic logic [31:0] note_rate(input int note);
    logic [63:0] inc;
    inc = 64'(A4_INC);
    if (note >= 69) begin
      for (int n = 69; n < note; n++) begin
        inc = 64'(32'((inc * SEMI_Q30) >> 30));
      end
    end else begin
      for (int n = note; n < 69; n++) begin
        inc = 64'(32'((inc << 30) / SEMI_Q30));
      end
    end
    return inc[31:0];
  endfunction

  function automatic logic [16*32-1:0] start_rates();
    logic [16*32-1:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k*32 +: 32] = note_rate(45 + ((k * 7) & 15));
    end
    return r;
  endfunction

  function automatic logic [16*33-1:0] delta_rates();
    logic [16*33-1:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k*33 +: 33] = {1'b0, note_rate(CHORD[k])} - {1'b0, note_rate(45 + ((k * 7) & 15))};
    end
    return r;
  endfunction

  localparam logic [16*32-1:0] START_RATES = start_rates();
  localparam logic [16*33-1:0] DELTA_RATES = delta_rates();

  function automatic logic signed [11:0] sat12(input logic signed [SW-1:0] x);
    if (x < -SW'(2048)) begin
      return -12'sd2048;
    end else if (x > SW'(2047)) begin
      return 12'sd2047;
    end else begin
      return 12'(x);
    end
  endfunction

endpackage

[rtl/core/saw_voice_bank_with_delay_reverb.sv]
// Sawtooth voice bank with cross-fed stereo delay and comb reverb, one audio
// sample per transfer. After reset the block clears the delay and reverb
// memories before in_ready rises. Each sample steps every voice, scales and
// mixes them, reduces delay_length by repeated subtraction of DELAY_DEPTH,
// passes the mix through the delay and reverb memories, and then waits until
// the previous result has left the output register; only after that is the
// next input transfer accepted.
// The voices are visited one at a time through a shared pair of multipliers
// (glide, then pitch scale), and each single-port memory is read and then
// written. The result waits in an output register, so the next sample can be
// taken while it is pending.
module saw_voice_bank_with_delay_reverb #(
  parameter int VOICE_COUNT  = 16,
  parameter int DELAY_DEPTH  = 16384,
  parameter int REVERB_DEPTH = 4096,
  parameter int REVERB_TAP   = 3067
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_gate,
  input  logic [15:0]        in_sweep_position,
  input  logic [21:0]        in_pitch_ratio,
  input  logic [13:0]        in_delay_length,
  input  logic [13:0]        in_reverb_gain,
  input  logic signed [11:0] in_audio_in_left,
  input  logic signed [11:0] in_audio_in_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] out_audio_out_left,
  output logic signed [11:0] out_audio_out_right
);

  svb_pkg::cmd_t    cmd;
  svb_pkg::status_t sts;

  svb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svb_dp #(
    .VOICE_COUNT  (VOICE_COUNT),
    .DELAY_DEPTH  (DELAY_DEPTH),
    .REVERB_DEPTH (REVERB_DEPTH),
    .REVERB_TAP   (REVERB_TAP)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_gate             (in_gate),
    .in_sweep_position   (in_sweep_position),
    .in_pitch_ratio      (in_pitch_ratio),
    .in_delay_length     (in_delay_length),
    .in_reverb_gain      (in_reverb_gain),
    .in_audio_in_left    (in_audio_in_left),
    .in_audio_in_right   (in_audio_in_right),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_audio_out_left  (out_audio_out_left),
    .out_audio_out_right (out_audio_out_right)
  );

endmodule

[rtl/core/svb_ctrl.sv]
module svb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  svb_pkg::status_t sts,
  output svb_pkg::cmd_t    cmd
);

  svb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      svb_pkg::ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = svb_pkg::ST_IDLE;
        end else begin
          cmd.clr_wr = 1'b1;
        end
      end
      svb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = svb_pkg::ST_VMUL1;
        end
      end
      svb_pkg::ST_VMUL1: begin
        cmd.vmul1 = 1'b1;
        state_nxt = svb_pkg::ST_VINC;
      end
      svb_pkg::ST_VINC: begin
        cmd.vinc  = 1'b1;
        state_nxt = svb_pkg::ST_VMUL2;
      end
      svb_pkg::ST_VMUL2: begin
        cmd.vmul2 = 1'b1;
        state_nxt = svb_pkg::ST_VACC;
      end
      svb_pkg::ST_VACC: begin
        cmd.vacc  = 1'b1;
        state_nxt = sts.vlast ? svb_pkg::ST_SMUL : svb_pkg::ST_VMUL1;
      end
      svb_pkg::ST_SMUL: begin
        cmd.smul  = 1'b1;
        state_nxt = svb_pkg::ST_SADD;
      end
      svb_pkg::ST_SADD: begin
        cmd.sadd  = 1'b1;
        state_nxt = svb_pkg::ST_DMOD;
      end
      svb_pkg::ST_DMOD: begin
        if (sts.dmod_done) begin
          state_nxt = svb_pkg::ST_DRD;
        end else begin
          cmd.dmod_step = 1'b1;
        end
      end
      svb_pkg::ST_DRD: begin
        cmd.drd   = 1'b1;
        state_nxt = svb_pkg::ST_DWAIT;
      end
      svb_pkg::ST_DWAIT: begin
        state_nxt = svb_pkg::ST_DWR;
      end
      svb_pkg::ST_DWR: begin
        cmd.dwr   = 1'b1;
        state_nxt = svb_pkg::ST_RRD;
      end
      svb_pkg::ST_RRD: begin
        cmd.rrd   = 1'b1;
        state_nxt = svb_pkg::ST_RWAIT;
      end
      svb_pkg::ST_RWAIT: begin
        state_nxt = svb_pkg::ST_RWR;
      end
      svb_pkg::ST_RWR: begin
        cmd.rwr   = 1'b1;
        state_nxt = svb_pkg::ST_RMIX;
      end
      svb_pkg::ST_RMIX: begin
        cmd.rmix  = 1'b1;
        state_nxt = svb_pkg::ST_DONE;
      end
      svb_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = svb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/svb_dp.sv]
module svb_dp #(
  parameter int VOICE_COUNT  = 16,
  parameter int DELAY_DEPTH  = 16384,
  parameter int REVERB_DEPTH = 4096,
  parameter int REVERB_TAP   = 3067
) (
  input  logic                clk,
  input  logic                rst_n,
  input  svb_pkg::cmd_t       cmd,
  output svb_pkg::status_t    sts,
  input  logic                in_gate,
  input  logic [15:0]         in_sweep_position,
  input  logic [21:0]         in_pitch_ratio,
  input  logic [13:0]         in_delay_length,
  input  logic [13:0]         in_reverb_gain,
  input  logic signed [11:0]  in_audio_in_left,
  input  logic signed [11:0]  in_audio_in_right,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [11:0]  out_audio_out_left,
  output logic signed [11:0]  out_audio_out_right
);

  localparam int SW    = svb_pkg::SW;
  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int ACC_W = 12 + VW;
  localparam int DA_W  = $clog2(DELAY_DEPTH);
  localparam int DX_W  = ((DA_W > 14) ? DA_W : 14) + 2;
  localparam int RA_W  = $clog2(REVERB_DEPTH);
  localparam int RX_W  = RA_W + 1;
  localparam int TAPM  = REVERB_TAP % REVERB_DEPTH;
  localparam int MAXD  = (DELAY_DEPTH > REVERB_DEPTH) ? DELAY_DEPTH : REVERB_DEPTH;
  localparam int CL_W  = $clog2(MAXD) + 1;

  logic        [31:0]       phase_r [VOICE_COUNT];
  logic        [14:0]       env_r;
  logic        [15:0]       pos_r;
  logic        [21:0]       ratio_r;
  logic        [13:0]       dmod_r;
  logic        [13:0]       gain_r;
  logic signed [11:0]       ain_l_r, ain_r_r;
  logic        [VW-1:0]     vc_r;
  logic signed [49:0]       p1_r;
  logic        [31:0]       inc_r;
  logic        [53:0]       p2_r;
  logic signed [ACC_W-1:0]  acc_l_r, acc_r_r;
  logic signed [ACC_W+15:0] ml_r, mr_r;
  logic signed [SW-1:0]     l_r, r_r;
  logic signed [26:0]       rm_r;
  logic        [DA_W-1:0]   dwi_r;
  logic        [RA_W-1:0]   rwi_r;
  logic        [CL_W-1:0]   clr_r;
  logic                     out_valid_r;
  logic signed [11:0]       out_l_r, out_r_r;

  logic signed [11:0] dmem_l [DELAY_DEPTH];
  logic signed [11:0] dmem_r [DELAY_DEPTH];
  logic signed [11:0] rmem [REVERB_DEPTH];
  logic signed [11:0] dl_q, dr_q, wet_q;

  logic        [3:0]        tidx;
  logic        [7:0]        vc8;
  logic        [31:0]       nphase;
  logic signed [11:0]       saw;
  logic signed [16:0]       env_diff;
  logic        [DX_W-1:0]   dsub;
  logic        [DA_W-1:0]   drd_a;
  logic        [RX_W-1:0]   rsub;
  logic        [RA_W-1:0]   rrd_a;
  logic                     d_we, r_we;
  logic        [DA_W-1:0]   d_wa;
  logic        [RA_W-1:0]   r_wa;
  logic signed [11:0]       dwd_l, dwd_r, rwd;
  logic signed [16:0]       mono;
  logic signed [SW-1:0]     rin;

  assign vc8      = 8'(vc_r);
  assign tidx     = 4'(vc8);
  assign nphase   = phase_r[vc_r] + p2_r[47:16];
  assign saw      = $signed({~nphase[31], nphase[30:20]});
  assign env_diff = (in_gate ? 17'sd32767 : 17'sd0) - $signed({2'b00, env_r});

  assign dsub  = DX_W'(dwi_r) - DX_W'(dmod_r);
  assign drd_a = DA_W'(dsub[DX_W-1] ? dsub + DX_W'(DELAY_DEPTH) : dsub);
  assign rsub  = RX_W'(rwi_r) - RX_W'(TAPM);
  assign rrd_a = RA_W'(rsub[RX_W-1] ? rsub + RX_W'(REVERB_DEPTH) : rsub);

  assign mono = (17'(l_r) + 17'(r_r)) >>> 1;
  assign rin  = SW'(mono) + SW'((14'(wet_q) * 14'sd3) >>> 2);

  assign sts.clr_done  = (clr_r == CL_W'(MAXD));
  assign sts.dmod_done = (DX_W'(dmod_r) < DX_W'(DELAY_DEPTH));
  assign sts.vlast     = (vc_r == VW'(VOICE_COUNT - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        phase_r[i] <= 32'(svb_pkg::PHASE_SEED * 32'(i + 1));
      end
      env_r       <= 15'(svb_pkg::ENV_FULL);
      dwi_r       <= '0;
      rwi_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      vc_r        <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.latch) begin
        env_r   <= 15'($signed({2'b00, env_r}) + (env_diff >>> 7));
        pos_r   <= in_sweep_position;
        ratio_r <= in_pitch_ratio;
        dmod_r  <= in_delay_length;
        gain_r  <= in_reverb_gain;
        ain_l_r <= in_audio_in_left;
        ain_r_r <= in_audio_in_right;
        vc_r    <= '0;
        acc_l_r <= '0;
        acc_r_r <= '0;
      end
      if (cmd.vmul1) begin
        p1_r <= $signed(svb_pkg::DELTA_RATES[tidx*33 +: 33]) * $signed({1'b0, pos_r});
      end
      if (cmd.vinc) begin
        inc_r <= svb_pkg::START_RATES[tidx*32 +: 32] + p1_r[47:16];
      end
      if (cmd.vmul2) begin
        p2_r <= inc_r * ratio_r;
      end
      if (cmd.vacc) begin
        phase_r[vc_r] <= nphase;
        if (vc_r[0]) begin
          acc_r_r <= acc_r_r + ACC_W'(saw);
        end else begin
          acc_l_r <= acc_l_r + ACC_W'(saw);
        end
        vc_r <= vc_r + 1'b1;
      end
      if (cmd.smul) begin
        ml_r <= acc_l_r * $signed({1'b0, env_r});
        mr_r <= acc_r_r * $signed({1'b0, env_r});
      end
      if (cmd.sadd) begin
        l_r <= SW'(ml_r >>> 18) + SW'(ain_l_r >>> 1);
        r_r <= SW'(mr_r >>> 18) + SW'(ain_r_r >>> 1);
      end
      if (cmd.dmod_step) begin
        dmod_r <= 14'(DX_W'(dmod_r) - DX_W'(DELAY_DEPTH));
      end
      if (cmd.dwr) begin
        l_r   <= l_r + SW'(dl_q >>> 1);
        r_r   <= r_r + SW'(dr_q >>> 1);
        dwi_r <= (dwi_r == DA_W'(DELAY_DEPTH - 1)) ? '0 : dwi_r + 1'b1;
      end
      if (cmd.rwr) begin
        rm_r  <= wet_q * $signed({1'b0, gain_r});
        rwi_r <= (rwi_r == RA_W'(REVERB_DEPTH - 1)) ? '0 : rwi_r + 1'b1;
      end
      if (cmd.rmix) begin
        l_r <= l_r + SW'(rm_r >>> 15);
        r_r <= r_r - SW'(rm_r >>> 15);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        out_l_r     <= svb_pkg::sat12(l_r);
        out_r_r     <= svb_pkg::sat12(r_r);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    d_we  = cmd.dwr || (cmd.clr_wr && (clr_r < CL_W'(DELAY_DEPTH)));
    d_wa  = cmd.dwr ? dwi_r : DA_W'(clr_r);
    dwd_l = cmd.dwr ? svb_pkg::sat12(l_r + SW'(dr_q >>> 1)) : '0;
    dwd_r = cmd.dwr ? svb_pkg::sat12(r_r + SW'(dl_q >>> 1)) : '0;
    r_we  = cmd.rwr || (cmd.clr_wr && (clr_r < CL_W'(REVERB_DEPTH)));
    r_wa  = cmd.rwr ? rwi_r : RA_W'(clr_r);
    rwd   = cmd.rwr ? svb_pkg::sat12(rin) : '0;
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem_l[d_wa] <= dwd_l;
    end
    if (cmd.drd) begin
      dl_q <= dmem_l[drd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem_r[d_wa] <= dwd_r;
    end
    if (cmd.drd) begin
      dr_q <= dmem_r[drd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_wa] <= rwd;
    end
    if (cmd.rrd) begin
      wet_q <= rmem[rrd_a];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_audio_out_left  = out_l_r;
  assign out_audio_out_right = out_r_r;

endmodule
